// ===== design/wds_pkg.sv =====
package wds_pkg;

    // Sample width at the block boundary. The datapath works in Q.23 internally.
    localparam int SAMPLE_BITS = 24;

    localparam int FRAC        = 23;
    localparam int DRIVE_W     = 13;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int Y_W         = 29;   // exp argument, unsigned Q6.23
    localparam int E_W         = 31;   // exp result, unsigned Q1.30
    localparam int NUM_W       = 55;   // divider dividend
    localparam int DEN_W       = 32;   // divider divisor
    localparam int DIV_STEPS   = 28;   // quotient bits
    localparam int EXP_TERMS   = 14;
    localparam int EXP_LIMIT   = 24;
    localparam int EXP_LAT     = 1 + 3 * EXP_TERMS + (EXP_LIMIT - 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 4'd1;

    // Shaping modes.
    localparam logic [MODE_W-1:0] MODE_OVERDRIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FUZZ      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TUBE      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLIP      = 2'd3;

    localparam logic [DRIVE_W-1:0] DRIVE_FULL = 13'd4096;

    // Signed Q6.23 working value.
    typedef logic signed [29:0] t_qv;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              neg;
        t_qv               val;
    } t_ctx;

    localparam t_qv K_0P8  = 30'sd6710886;
    localparam t_qv K_1P1  = 30'sd9227469;
    localparam t_qv K_0P5  = 30'sd4194304;
    localparam t_qv K_0P7  = 30'sd5872026;
    localparam t_qv K_0P3  = 30'sd2516582;
    localparam t_qv K_1P5  = 30'sd12582912;
    localparam t_qv K_1P2  = 30'sd10066330;
    localparam t_qv K_0P9  = 30'sd7549747;
    localparam t_qv K_0P2  = 30'sd1677722;
    localparam t_qv ONE_Q23 = 30'sd8388608;
    localparam logic [29:0] K_27 = 30'd226492416;

    localparam logic [E_W-1:0] ONE_Q30   = 31'd1073741824;
    localparam logic [28:0]    INV_E_Q30 = 29'd395007542;

    // floor(2^32 / k); k = 1 is served by the correction step.
    function automatic logic [31:0] recip(input int k);
        logic [31:0] m;
        case (k)
            1:       m = 32'hFFFFFFFF;
            2:       m = 32'd2147483648;
            3:       m = 32'd1431655765;
            4:       m = 32'd1073741824;
            5:       m = 32'd858993459;
            6:       m = 32'd715827882;
            7:       m = 32'd613566756;
            8:       m = 32'd536870912;
            9:       m = 32'd477218588;
            10:      m = 32'd429496729;
            11:      m = 32'd390451572;
            12:      m = 32'd357913941;
            13:      m = 32'd330382099;
            14:      m = 32'd306783378;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    // Q.23 product, floored.
    function automatic t_qv qmul(input t_qv a, input t_qv b);
        logic signed [59:0] p;
        p = a * b;
        return p[52:23];
    endfunction

    function automatic t_qv qabs(input t_qv a);
        return (a < 0) ? -a : a;
    endfunction

endpackage

// ===== design/wds_exp.sv =====
module wds_exp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [wds_pkg::Y_W-1:0] i_y,
    input  wds_pkg::t_ctx         i_ctx,
    output logic                  o_vld,
    output logic [wds_pkg::E_W-1:0] o_e,
    output wds_pkg::t_ctx         o_ctx
);
    import wds_pkg::*;

    localparam int MUL_STAGES = EXP_LIMIT - 1;

    // Per Horner term: state after the term.
    logic              r_h_vld  [0:EXP_TERMS];
    t_ctx              r_h_ctx  [0:EXP_TERMS];
    logic [5:0]        r_h_n    [0:EXP_TERMS];
    logic              r_h_zero [0:EXP_TERMS];
    logic [29:0]       r_h_f    [0:EXP_TERMS];
    logic [E_W-1:0]    r_h_r    [0:EXP_TERMS];

    // Per step of the integer-part product chain.
    logic              r_m_vld  [0:MUL_STAGES-1];
    t_ctx              r_m_ctx  [0:MUL_STAGES-1];
    logic [5:0]        r_m_n    [0:MUL_STAGES-1];
    logic              r_m_zero [0:MUL_STAGES-1];
    logic [E_W-1:0]    r_m_r    [0:MUL_STAGES-1];

    logic [5:0] n_n;
    assign n_n = i_y[Y_W-1:FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld[0] <= 1'b0;
        end else begin
            r_h_vld[0] <= i_vld;
        end
        r_h_ctx[0]  <= i_ctx;
        r_h_n[0]    <= n_n;
        r_h_zero[0] <= (n_n >= 6'(EXP_LIMIT));
        r_h_f[0]    <= {i_y[FRAC-1:0], 7'd0};
        r_h_r[0]    <= ONE_Q30;
    end

    // Each term takes three stages: the product, the reciprocal product and the
    // correction of the quotient estimate.
    for (genvar gi = 0; gi < EXP_TERMS; gi++) begin : g_term
        localparam int          KI = EXP_TERMS - gi;
        localparam logic [3:0]  KV = 4'(KI);
        localparam logic [31:0] KM = recip(KI);

        logic              r_a_vld;
        t_ctx              r_a_ctx;
        logic [5:0]        r_a_n;
        logic              r_a_zero;
        logic [29:0]       r_a_f;
        logic [29:0]       r_a_p;
        logic              r_b_vld;
        t_ctx              r_b_ctx;
        logic [5:0]        r_b_n;
        logic              r_b_zero;
        logic [29:0]       r_b_f;
        logic [29:0]       r_b_p;
        logic [29:0]       r_b_q0;
        logic [60:0]       n_fr;
        logic [61:0]       n_pm;
        logic [33:0]       n_rem;
        logic [29:0]       n_q;

        assign n_fr  = r_h_f[gi] * r_h_r[gi];
        assign n_pm  = r_a_p * KM;
        assign n_rem = {4'd0, r_b_p} - r_b_q0 * KV;
        assign n_q   = r_b_q0 + 30'(n_rem >= 34'(KV));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld        <= 1'b0;
                r_b_vld        <= 1'b0;
                r_h_vld[gi+1]  <= 1'b0;
            end else begin
                r_a_vld        <= r_h_vld[gi];
                r_b_vld        <= r_a_vld;
                r_h_vld[gi+1]  <= r_b_vld;
            end
            r_a_ctx  <= r_h_ctx[gi];
            r_a_n    <= r_h_n[gi];
            r_a_zero <= r_h_zero[gi];
            r_a_f    <= r_h_f[gi];
            r_a_p    <= n_fr[59:30];
            r_b_ctx  <= r_a_ctx;
            r_b_n    <= r_a_n;
            r_b_zero <= r_a_zero;
            r_b_f    <= r_a_f;
            r_b_p    <= r_a_p;
            r_b_q0   <= n_pm[61:32];
            r_h_ctx[gi+1]  <= r_b_ctx;
            r_h_n[gi+1]    <= r_b_n;
            r_h_zero[gi+1] <= r_b_zero;
            r_h_f[gi+1]    <= r_b_f;
            r_h_r[gi+1]    <= ONE_Q30 - E_W'(n_q);
        end
    end

    // One multiplication by 1/e per stage, applied while the stage index is
    // below the integer part of the argument.
    for (genvar gj = 0; gj < MUL_STAGES; gj++) begin : g_mul
        logic              p_vld;
        t_ctx              p_ctx;
        logic [5:0]        p_n;
        logic              p_zero;
        logic [E_W-1:0]    p_r;
        logic [59:0]       n_prod;

        if (gj == 0) begin : g_first
            assign p_vld  = r_h_vld[EXP_TERMS];
            assign p_ctx  = r_h_ctx[EXP_TERMS];
            assign p_n    = r_h_n[EXP_TERMS];
            assign p_zero = r_h_zero[EXP_TERMS];
            assign p_r    = r_h_r[EXP_TERMS];
        end else begin : g_next
            assign p_vld  = r_m_vld[gj-1];
            assign p_ctx  = r_m_ctx[gj-1];
            assign p_n    = r_m_n[gj-1];
            assign p_zero = r_m_zero[gj-1];
            assign p_r    = r_m_r[gj-1];
        end

        assign n_prod = p_r * INV_E_Q30;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[gj] <= 1'b0;
            end else begin
                r_m_vld[gj] <= p_vld;
            end
            r_m_ctx[gj]  <= p_ctx;
            r_m_n[gj]    <= p_n;
            r_m_zero[gj] <= p_zero;
            r_m_r[gj]    <= (p_n > 6'(gj)) ? E_W'(n_prod[59:30]) : p_r;
        end
    end

    assign o_vld = r_m_vld[MUL_STAGES-1];
    assign o_ctx = r_m_ctx[MUL_STAGES-1];
    assign o_e   = r_m_zero[MUL_STAGES-1] ? '0 : r_m_r[MUL_STAGES-1];

    a_exp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_e <= ONE_Q30))
        else $error("exp result above one");

endmodule

// ===== design/wds_div.sv =====
module wds_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [wds_pkg::NUM_W-1:0] i_num,
    input  logic [wds_pkg::DEN_W-1:0] i_den,
    input  wds_pkg::t_ctx             i_ctx,
    output logic                      o_vld,
    output logic [wds_pkg::DIV_STEPS-1:0] o_q,
    output wds_pkg::t_ctx             o_ctx
);
    import wds_pkg::*;

    logic                 r_d_vld [0:DIV_STEPS-1];
    t_ctx                 r_d_ctx [0:DIV_STEPS-1];
    logic [DEN_W-1:0]     r_d_rem [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_d_low [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] r_d_q   [0:DIV_STEPS-1];
    logic [DEN_W-1:0]     r_d_den [0:DIV_STEPS-1];

    // Restoring division, one quotient bit per stage. The dividend is known to
    // be below the divisor times 2^DIV_STEPS, so the partial remainder never
    // exceeds the divisor width.
    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_step
        logic                 p_vld;
        t_ctx                 p_ctx;
        logic [DEN_W-1:0]     p_rem;
        logic [DIV_STEPS-1:0] p_low;
        logic [DIV_STEPS-1:0] p_q;
        logic [DEN_W-1:0]     p_den;
        logic [DEN_W:0]       n_t;
        logic                 n_ge;

        if (gi == 0) begin : g_first
            assign p_vld = i_vld;
            assign p_ctx = i_ctx;
            assign p_rem = DEN_W'(i_num[NUM_W-1:DIV_STEPS]);
            assign p_low = i_num[DIV_STEPS-1:0];
            assign p_q   = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_vld = r_d_vld[gi-1];
            assign p_ctx = r_d_ctx[gi-1];
            assign p_rem = r_d_rem[gi-1];
            assign p_low = r_d_low[gi-1];
            assign p_q   = r_d_q[gi-1];
            assign p_den = r_d_den[gi-1];
        end

        assign n_t  = {p_rem, p_low[DIV_STEPS-1]};
        assign n_ge = (n_t >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[gi] <= 1'b0;
            end else begin
                r_d_vld[gi] <= p_vld;
            end
            r_d_ctx[gi] <= p_ctx;
            r_d_rem[gi] <= n_ge ? DEN_W'(n_t - {1'b0, p_den}) : n_t[DEN_W-1:0];
            r_d_low[gi] <= {p_low[DIV_STEPS-2:0], 1'b0};
            r_d_q[gi]   <= {p_q[DIV_STEPS-2:0], n_ge};
            r_d_den[gi] <= p_den;
        end
    end

    assign o_vld = r_d_vld[DIV_STEPS-1];
    assign o_q   = r_d_q[DIV_STEPS-1];
    assign o_ctx = r_d_ctx[DIV_STEPS-1];

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (r_d_rem[DIV_STEPS-1] < r_d_den[DIV_STEPS-1]))
        else $error("divider remainder not below divisor");

endmodule

// ===== design/four_mode_distortion_waveshaper_core.sv =====
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  ---------------------------------
// input     in         start, busy               i_sample_in (signed Q1.23)
// result    out        o_strobe (one cycle)      o_sample_out (signed Q1.23)
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A word is taken at every clock edge with start high; busy stays low, so a new
// sample may enter every cycle. Each sample passes, in series, through the
// three exp units (66 stages each, one Horner term per three stages and one
// 1/e product per stage) and the three 28-stage restoring dividers.
// The synchronous, active-low reset clears every valid bit and both registers.
// The receiver cannot stall, so the pipeline never holds.
module four_mode_distortion_waveshaper_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [wds_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                  o_strobe,
    output logic signed [wds_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import wds_pkg::*;

    localparam int DIV_LAT = DIV_STEPS;
    localparam int LAT = 3 + EXP_LAT + 1 + DIV_LAT + 3 + EXP_LAT + 1 + DIV_LAT
                       + 1 + EXP_LAT + 1 + DIV_LAT + 1;
    localparam int SH_UP = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;
    localparam int SH_DN = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
    localparam logic signed [33:0] OUT_HI = (34'sd1 <<< (SAMPLE_BITS - 1)) - 34'sd1;
    localparam logic signed [33:0] OUT_LO = -(34'sd1 <<< (SAMPLE_BITS - 1));

    // Configuration registers. The port never pushes back.
    logic [DRIVE_W-1:0] r_drive;
    logic [MODE_W-1:0]  r_mode;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
            r_mode  <= MODE_OVERDRIVE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DRIVE: r_drive <= i_cfg_data[DRIVE_W-1:0];
                CFG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Stage T0: capture the sample in Q.23 together with the saturated drive
    // and the mode, so later configuration writes never touch items in flight.
    logic signed [32:0] n_x_wide;
    logic               r_t0_vld;
    logic signed [23:0] r_t0_x;
    logic [DRIVE_W-1:0] r_t0_d;
    logic [MODE_W-1:0]  r_t0_mode;

    assign n_x_wide = ((33'(i_sample_in)) <<< SH_DN) >>> SH_UP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
        end else begin
            r_t0_vld <= start && !busy;
        end
        r_t0_x    <= n_x_wide[23:0];
        r_t0_d    <= (r_drive > DRIVE_FULL) ? DRIVE_FULL : r_drive;
        r_t0_mode <= r_mode;
    end

    // Stage T1: apply the gain 1 + 15 * drive and work out the clip threshold.
    logic [17:0]        n_gain;
    logic signed [41:0] n_sp;
    logic [34:0]        n_tp;
    t_qv                n_th;
    logic               r_t1_vld;
    t_qv                r_t1_s;
    t_qv                r_t1_th;
    logic [MODE_W-1:0]  r_t1_mode;

    assign n_gain = 18'd4096 + 18'd15 * 18'(r_t0_d);
    assign n_sp   = r_t0_x * $signed(n_gain);
    assign n_tp   = 35'(K_0P3) * 35'(r_t0_d);
    assign n_th   = K_0P7 - t_qv'(n_tp >> 12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
        end else begin
            r_t1_vld <= r_t0_vld;
        end
        r_t1_s    <= n_sp[41:12];
        r_t1_th   <= (n_th < K_0P2) ? K_0P2 : n_th;
        r_t1_mode <= r_t0_mode;
    end

    // Stage T2: the mode's first scaling. Tube mode takes the magnitude and
    // remembers which side of the curve it is on; clip mode limits first.
    t_qv                n_a;
    t_qv                n_k;
    logic               n_pos;
    logic               r_t2_vld;
    t_qv                r_t2_w;
    logic               r_t2_pos;
    logic [MODE_W-1:0]  r_t2_mode;

    always_comb begin
        n_pos = (r_t1_s > 0);
        case (r_t1_mode)
            MODE_OVERDRIVE: begin
                n_a = r_t1_s;
                n_k = K_0P8;
            end
            MODE_FUZZ: begin
                n_a = r_t1_s;
                n_k = K_0P5;
            end
            MODE_TUBE: begin
                n_a = n_pos ? r_t1_s : -r_t1_s;
                n_k = n_pos ? K_0P8 : K_1P2;
            end
            default: begin
                if (r_t1_s > r_t1_th) begin
                    n_a = r_t1_th;
                end else if (r_t1_s < -r_t1_th) begin
                    n_a = -r_t1_th;
                end else begin
                    n_a = r_t1_s;
                end
                n_k = K_1P2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_vld <= 1'b0;
        end else begin
            r_t2_vld <= r_t1_vld;
        end
        r_t2_w    <= qmul(n_a, n_k);
        r_t2_pos  <= n_pos;
        r_t2_mode <= r_t1_mode;
    end

    // First exp unit: tanh argument for fuzz and clip, the tube exponent.
    logic [Y_W-1:0] n_y1;
    t_ctx           n_c1;
    logic           e1_vld;
    logic [E_W-1:0] e1_e;
    t_ctx           e1_ctx;

    always_comb begin
        n_c1.mode = r_t2_mode;
        n_c1.val  = r_t2_w;
        n_c1.neg  = (r_t2_w < 0);
        case (r_t2_mode)
            MODE_FUZZ, MODE_CLIP: n_y1 = Y_W'(qabs(r_t2_w) <<< 1);
            MODE_TUBE: begin
                n_y1     = Y_W'(r_t2_w);
                n_c1.neg = !r_t2_pos;
            end
            default:   n_y1 = '0;
        endcase
    end

    wds_exp u_exp1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t2_vld),
        .i_y     (n_y1),
        .i_ctx   (n_c1),
        .o_vld   (e1_vld),
        .o_e     (e1_e),
        .o_ctx   (e1_ctx)
    );

    // Stage T4: build the first division. Overdrive divides the rational
    // curve, fuzz and clip finish a tanh, tube finishes here.
    logic [28:0]      n_av;
    logic [58:0]      n_odn;
    logic [32:0]      n_odd;
    t_qv              n_tm;
    logic             r_t4_vld;
    logic [NUM_W-1:0] r_t4_num;
    logic [DEN_W-1:0] r_t4_den;
    t_ctx             r_t4_ctx;
    logic [NUM_W-1:0] n_num4;
    logic [DEN_W-1:0] n_den4;
    t_ctx             n_c4;

    assign n_av  = 29'(qabs(e1_ctx.val));
    assign n_odn = n_av * (K_27 + 30'(n_av));
    assign n_odd = 33'(K_27) + 33'd26 * 33'(n_av);
    assign n_tm  = ONE_Q23 - t_qv'(e1_e >> 7);

    always_comb begin
        n_c4   = e1_ctx;
        n_num4 = NUM_W'(ONE_Q30 - e1_e) << FRAC;
        n_den4 = DEN_W'(ONE_Q30) + DEN_W'(e1_e);
        case (e1_ctx.mode)
            MODE_OVERDRIVE: begin
                n_num4 = n_odn[NUM_W-1:0];
                n_den4 = n_odd[DEN_W-1:0];
            end
            MODE_TUBE: begin
                n_num4   = '0;
                n_den4   = DEN_W'(1);
                n_c4.val = e1_ctx.neg ? -n_tm : n_tm;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t4_vld <= 1'b0;
        end else begin
            r_t4_vld <= e1_vld;
        end
        r_t4_num <= n_num4;
        r_t4_den <= n_den4;
        r_t4_ctx <= n_c4;
    end

    logic                 d1_vld;
    logic [DIV_STEPS-1:0] d1_q;
    t_ctx                 d1_ctx;

    wds_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t4_vld),
        .i_num   (r_t4_num),
        .i_den   (r_t4_den),
        .i_ctx   (r_t4_ctx),
        .o_vld   (d1_vld),
        .o_q     (d1_q),
        .o_ctx   (d1_ctx)
    );

    // Stages P1 to P3: the middle arithmetic of each mode. Fuzz builds the
    // octave term and its weighted sum here; the others only scale or pass.
    t_qv  n_t1;
    t_qv  n_p1a;
    t_qv  n_p1b;
    logic r_p1_vld;
    t_qv  r_p1_a;
    t_qv  r_p1_b;
    t_ctx r_p1_ctx;
    logic r_p2_vld;
    t_qv  r_p2_a;
    t_ctx r_p2_ctx;
    logic r_p3_vld;
    t_qv  r_p3_a;
    t_ctx r_p3_ctx;

    assign n_t1 = d1_ctx.neg ? -t_qv'(d1_q) : t_qv'(d1_q);

    always_comb begin
        n_p1b = qmul(n_t1, K_0P7);
        case (d1_ctx.mode)
            MODE_OVERDRIVE: n_p1a = qmul(n_t1, K_1P1);
            MODE_FUZZ:      n_p1a = qmul(n_t1, qabs(n_t1));
            MODE_TUBE:      n_p1a = qmul(d1_ctx.val, K_0P9);
            default:        n_p1a = n_t1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p1_vld <= d1_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
        r_p1_a   <= n_p1a;
        r_p1_b   <= n_p1b;
        r_p1_ctx <= d1_ctx;
        r_p2_a   <= (r_p1_ctx.mode == MODE_FUZZ) ? r_p1_b + qmul(r_p1_a, K_0P3) : r_p1_a;
        r_p2_ctx <= r_p1_ctx;
        r_p3_a   <= (r_p2_ctx.mode == MODE_FUZZ) ? qmul(r_p2_a, K_1P5) : r_p2_a;
        r_p3_ctx <= r_p2_ctx;
    end

    // Second tanh, used by fuzz only; the other modes ride along in the context.
    logic [Y_W-1:0] n_y2;
    t_ctx           n_c2;
    logic           e2_vld;
    logic [E_W-1:0] e2_e;
    t_ctx           e2_ctx;

    always_comb begin
        n_c2      = r_p3_ctx;
        n_c2.val  = r_p3_a;
        n_c2.neg  = (r_p3_a < 0);
        n_y2      = (r_p3_ctx.mode == MODE_FUZZ) ? Y_W'(qabs(r_p3_a) <<< 1) : '0;
    end

    wds_exp u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p3_vld),
        .i_y     (n_y2),
        .i_ctx   (n_c2),
        .o_vld   (e2_vld),
        .o_e     (e2_e),
        .o_ctx   (e2_ctx)
    );

    logic             r_t6_vld;
    logic [NUM_W-1:0] r_t6_num;
    logic [DEN_W-1:0] r_t6_den;
    t_ctx             r_t6_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t6_vld <= 1'b0;
        end else begin
            r_t6_vld <= e2_vld;
        end
        r_t6_num <= NUM_W'(ONE_Q30 - e2_e) << FRAC;
        r_t6_den <= DEN_W'(ONE_Q30) + DEN_W'(e2_e);
        r_t6_ctx <= e2_ctx;
    end

    logic                 d2_vld;
    logic [DIV_STEPS-1:0] d2_q;
    t_ctx                 d2_ctx;

    wds_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t6_vld),
        .i_num   (r_t6_num),
        .i_den   (r_t6_den),
        .i_ctx   (r_t6_ctx),
        .o_vld   (d2_vld),
        .o_q     (d2_q),
        .o_ctx   (d2_ctx)
    );

    // Stage F: pick the shaped value and scale it for the output soft limit.
    t_qv  n_sf;
    t_qv  n_f;
    logic r_f_vld;
    t_qv  r_f_v;
    t_ctx r_f_ctx;

    always_comb begin
        if (d2_ctx.mode == MODE_FUZZ) begin
            n_sf = d2_ctx.neg ? -t_qv'(d2_q) : t_qv'(d2_q);
        end else begin
            n_sf = d2_ctx.val;
        end
        n_f = qmul(n_sf, K_0P9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= d2_vld;
        end
        r_f_v   <= n_f;
        r_f_ctx <= d2_ctx;
    end

    logic [Y_W-1:0] n_y3;
    t_ctx           n_c3;
    logic           e3_vld;
    logic [E_W-1:0] e3_e;
    t_ctx           e3_ctx;

    always_comb begin
        n_c3     = r_f_ctx;
        n_c3.val = r_f_v;
        n_c3.neg = (r_f_v < 0);
        n_y3     = Y_W'(qabs(r_f_v) <<< 1);
    end

    wds_exp u_exp3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_f_vld),
        .i_y     (n_y3),
        .i_ctx   (n_c3),
        .o_vld   (e3_vld),
        .o_e     (e3_e),
        .o_ctx   (e3_ctx)
    );

    logic             r_t8_vld;
    logic [NUM_W-1:0] r_t8_num;
    logic [DEN_W-1:0] r_t8_den;
    t_ctx             r_t8_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t8_vld <= 1'b0;
        end else begin
            r_t8_vld <= e3_vld;
        end
        r_t8_num <= NUM_W'(ONE_Q30 - e3_e) << FRAC;
        r_t8_den <= DEN_W'(ONE_Q30) + DEN_W'(e3_e);
        r_t8_ctx <= e3_ctx;
    end

    logic                 d3_vld;
    logic [DIV_STEPS-1:0] d3_q;
    t_ctx                 d3_ctx;

    wds_div u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t8_vld),
        .i_num   (r_t8_num),
        .i_den   (r_t8_den),
        .i_ctx   (r_t8_ctx),
        .o_vld   (d3_vld),
        .o_q     (d3_q),
        .o_ctx   (d3_ctx)
    );

    // Output stage: sign the soft-limited value, move it to the port format
    // and saturate, so that +1.0 becomes the largest positive code.
    t_qv                n_t3;
    logic signed [33:0] n_ow;
    logic signed [33:0] n_os;
    logic               r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out;

    assign n_t3 = d3_ctx.neg ? -t_qv'(d3_q) : t_qv'(d3_q);
    assign n_ow = ((34'(n_t3)) <<< SH_UP) >>> SH_DN;

    always_comb begin
        if (n_ow > OUT_HI) begin
            n_os = OUT_HI;
        end else if (n_ow < OUT_LO) begin
            n_os = OUT_LO;
        end else begin
            n_os = n_ow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= d3_vld;
        end
        r_out <= n_os[SAMPLE_BITS-1:0];
    end

    assign o_strobe     = r_out_vld;
    assign o_sample_out = r_out;

    // Every result must trace back to a sample offered earlier with start high.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result without a matching input word");

endmodule

// ===== dv/tb_four_mode_distortion_waveshaper_core.sv =====
module tb_four_mode_distortion_waveshaper_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wds_pkg::*;

    // PIPE_LAT is the pipeline depth. The watchdog trips when the idle counter,
    // which runs while no word moves on any channel, reaches IDLE_LIMIT.
    localparam int PIPE_LAT  = 293;
    localparam int IDLE_LIMIT = 20000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic                          o_strobe;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    four_mode_distortion_waveshaper_core DUT (.*);

    always #1 i_clk = ~i_clk;

    // Shadow copies of the two registers, as the block should hold them.
    logic [DRIVE_W-1:0] drive_reg = '0;
    logic [MODE_W-1:0]  mode_reg  = MODE_OVERDRIVE;

    logic signed [SAMPLE_BITS-1:0] shaped_q[$];
    int  fail_count = 0;
    int  idle_cycles = 0;

    // Arithmetic shift right that floors, on 64-bit values.
    function automatic longint floor_shift(input longint v, input int sh);
        return v >>> sh;
    endfunction

    function automatic longint q23_mul(input longint a, input longint b);
        return (a * b) >>> 23;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // exp(-y) in Q.30 for y >= 0 in Q.23, via a truncated Horner series for the
    // fraction followed by repeated products with 1/e for the integer part.
    function automatic longint unsigned decay_q30(input longint y);
        longint unsigned n, f, r;
        if (y < 0) y = 0;
        n = longint'(y) >> 23;
        if (n >= 24) return 0;
        f = (longint'(y) & 64'h7FFFFF) << 7;
        r = 64'd1 << 30;
        for (int k = 14; k >= 1; k--)
            r = (64'd1 << 30) - ((f * r) >> 30) / k;
        while (n > 0) begin
            r = (r * 64'd395007542) >> 30;
            n--;
        end
        return r;
    endfunction

    function automatic longint soft_tanh(input longint x);
        longint a;
        longint unsigned e, t;
        a = magnitude(x);
        if (2 * a >= (longint'(24) << 23))
            return (x < 0) ? -(longint'(1) << 23) : (longint'(1) << 23);
        e = decay_q30(2 * a);
        t = (((64'd1 << 30) - e) << 23) / ((64'd1 << 30) + e);
        return (x < 0) ? -longint'(t) : longint'(t);
    endfunction

    // Expected shaped sample for one input sample under the current settings.
    function automatic logic signed [SAMPLE_BITS-1:0] shape_sample(
        input logic signed [SAMPLE_BITS-1:0] smp);
        longint x, s, d, v, av, num, den, oct, th, t;
        x = smp;
        d = (drive_reg > DRIVE_FULL) ? 4096 : drive_reg;
        s = floor_shift(x * (4096 + 15 * d), 12);
        case (mode_reg)
            MODE_OVERDRIVE: begin
                v = q23_mul(s, K_0P8);
                av = magnitude(v);
                num = v * (27 * (longint'(1) << 23) + av);
                den = 27 * (longint'(1) << 23) + 26 * av;
                s = q23_mul(num / den, K_1P1);
            end
            MODE_FUZZ: begin
                v = soft_tanh(q23_mul(s, K_0P5));
                oct = q23_mul(v, magnitude(v));
                s = soft_tanh(q23_mul(q23_mul(v, K_0P7) + q23_mul(oct, K_0P3), K_1P5));
            end
            MODE_TUBE: begin
                if (s > 0)
                    s = (longint'(1) << 23) - longint'(decay_q30(q23_mul(s, K_0P8)) >> 7);
                else
                    s = -((longint'(1) << 23) - longint'(decay_q30(q23_mul(-s, K_1P2)) >> 7));
                s = q23_mul(s, K_0P9);
            end
            default: begin
                th = K_0P7 - floor_shift(K_0P3 * d, 12);
                if (th < K_0P2) th = K_0P2;
                if (s > th) s = th;
                else if (s < -th) s = -th;
                s = soft_tanh(q23_mul(s, K_1P2));
            end
        endcase
        t = soft_tanh(q23_mul(s, K_0P9));
        // A result of exactly +1.0 saturates to the top code.
        if (t > 8388607) t = 8388607;
        if (t < -8388608) t = -8388608;
        return t[SAMPLE_BITS-1:0];
    endfunction

    // Random gap: mostly none or short, now and then long.
    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return;
        start <= 1'b0;
        if (r < 95) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        else repeat ($urandom_range(10, 60)) @(posedge i_clk);
    endtask

    // Offers one sample word and holds it until the block takes it. Start is
    // dropped by whoever idles next, so words can follow with no gap.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        start <= 1'b1;
        i_sample_in <= smp;
        do @(posedge i_clk); while (busy);
        shaped_q.push_back(shape_sample(smp));
    endtask

    // Streams samples back to back with no gaps: start stays high throughout.
    task automatic send_burst(input int n);
        logic signed [SAMPLE_BITS-1:0] smp;
        for (int i = 0; i < n; i++) begin
            smp = SAMPLE_BITS'($urandom);
            start <= 1'b1;
            i_sample_in <= smp;
            do @(posedge i_clk); while (busy);
            shaped_q.push_back(shape_sample(smp));
        end
    endtask

    // Lets the pipeline drain before touching registers.
    task automatic wait_drained();
        start <= 1'b0;
        while (shaped_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DRIVE) drive_reg = val;
        else if (idx == CFG_MODE) mode_reg = val[MODE_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [CFG_DATA_W-1:0] drv,
                             input logic [MODE_W-1:0] md);
        wait_drained();
        write_reg(CFG_DRIVE, drv);
        write_reg(CFG_MODE, CFG_DATA_W'(md));
    endtask

    // Full-scale, zero, tiny and mid-level samples in every mode, at zero and
    // at full drive, and with a drive setting above full scale.
    task automatic test_directed();
        logic signed [SAMPLE_BITS-1:0] pts[6];
        logic [CFG_DATA_W-1:0] drv[3];
        pts = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1, 24'sh200000};
        drv = '{13'd0, DRIVE_FULL, 13'h1FFF};
        for (int m = 0; m < 4; m++)
            for (int j = 0; j < 3; j++) begin
                set_shape(drv[j], MODE_W'(m));
                foreach (pts[p]) send_sample(pts[p]);
            end
    endtask

    // Writes to unused register indexes must leave the settings alone.
    task automatic test_unused_index();
        set_shape(13'd1234, MODE_TUBE);
        write_reg(4'd2, 13'h1FFF);
        write_reg(4'd15, 13'h0003);
        for (int i = 0; i < 8; i++) send_sample(SAMPLE_BITS'($urandom));
    endtask

    // Random samples under a series of settings (random drive, modes in turn), with
    // random gaps and a gap-free burst in each phase.
    task automatic test_random();
        logic [CFG_DATA_W-1:0] drv;
        for (int ph = 0; ph < 24; ph++) begin
            case ($urandom_range(0, 3))
                0: drv = 13'd0;
                1: drv = DRIVE_FULL;
                2: drv = CFG_DATA_W'($urandom_range(4097, 8191));
                default: drv = CFG_DATA_W'($urandom_range(0, 4096));
            endcase
            set_shape(drv, MODE_W'(ph % 4));
            for (int i = 0; i < 55; i++) begin
                idle_gap();
                if ($urandom_range(0, 3) == 0)
                    send_sample(SAMPLE_BITS'(int'($urandom_range(0, 255)) - 128));
                else
                    send_sample(SAMPLE_BITS'($urandom));
            end
            send_burst(20);
        end
    endtask

    // Each strobed word is compared with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (shaped_q.size() == 0) begin
                $error("unexpected sample_out word %0d", o_sample_out);
                fail_count++;
            end else begin
                logic signed [SAMPLE_BITS-1:0] want;
                want = shaped_q.pop_front();
                if (o_sample_out !== want) begin
                    $error("sample_out mismatch: expected %0d, actual %0d", want, o_sample_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no traffic on any channel.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_unused_index();
        test_random();
        wait_drained();
        if (fail_count == 0 && shaped_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/wds_pkg.sv
design/wds_exp.sv
design/wds_div.sv
design/four_mode_distortion_waveshaper_core.sv
dv/tb_four_mode_distortion_waveshaper_core.sv
